// ===== rtl/grid_increasing_path_counter_assert.svh =====
// Assertion macros for the increasing-path counter checker.
`ifndef GRID_INCREASING_PATH_COUNTER_ASSERT_SVH
`define GRID_INCREASING_PATH_COUNTER_ASSERT_SVH

// Check a property on the rising clock edge, skipped while in reset.
`define GIPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on the rising clock edge, also while in reset.
`define GIPC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gipc_pkg.sv =====
// Shared types, constants and helpers of the increasing-path counter.
`default_nettype none
package gipc_pkg;
	localparam int DEF_MAX_ROWS    = 32;
	localparam int DEF_MAX_COLS    = 32;
	localparam int DEF_VALUE_WIDTH = 20;

	localparam int CELL_W  = 20;
	localparam int TOTAL_W = 30;
	localparam int CFG_W   = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [TOTAL_W-1:0] PATH_PRIME = 30'd1000000007;
	localparam logic [CFG_W-1:0]   SIZE_RESET = 6'd32;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CELL_RD,
		ST_CELL_CHK,
		ST_NB_RD,
		ST_NB_CHK,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	function automatic logic [TOTAL_W-1:0] mod_add(input logic [TOTAL_W-1:0] a,
		input logic [TOTAL_W-1:0] b);
		logic [TOTAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, PATH_PRIME}) begin
			s = s - {1'b0, PATH_PRIME};
		end
		return s[TOTAL_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/gipc_ifs.sv =====
// Valid/ready channel interfaces for grid cells and path totals.
`default_nettype none
interface gipc_cell_if import gipc_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_value;
	modport source (output valid, output cell_value, input ready);
	modport sink   (input valid, input cell_value, output ready);
endinterface

interface gipc_total_if import gipc_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] path_total;
	modport source (output valid, output path_total, input ready);
	modport sink   (input valid, input path_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/gipc_ram.sv =====
// Single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module gipc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/grid_increasing_path_counter.sv =====
// Top level of the grid increasing-path counter.
// Cells load one per cycle in row-major order into a value RAM while the block
// is in its load state; after the last cell the block sweeps the grid in
// passes, settling each cell once all its larger neighbors are settled, and
// emits the total modulo 1000000007. A visit of an unsettled cell reads the
// cell, then reads and checks each existing neighbor in turn through the one
// read port of each RAM, then settles the cell or marks the pass pending; a
// settled cell is passed over after its read. The number of passes is at most
// the longest increasing path. The output register lets the next grid load
// while a total waits.
`default_nettype none
module grid_increasing_path_counter import gipc_pkg::*; #(
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	gipc_cell_if.sink                 cell_in,
	gipc_total_if.source              total_out
);
	localparam int SLOTS = MAX_ROWS * MAX_COLS;
	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int CNT_W = TOTAL_W + 1;

	state_t                 state_q, state_d;
	logic [CFG_W-1:0]       num_rows_q, num_cols_q;
	logic [RW-1:0]          rows_eff, row_q, row_d;
	logic [CW-1:0]          cols_eff, col_q, col_d;
	logic [IW-1:0]          idx_q, idx_d, nb_addr, rd_addr;
	logic [VALUE_WIDTH-1:0] val_q, val_d, grid_rd, grid_wdata;
	logic [TOTAL_W-1:0]     acc_q, acc_d, total_q, total_d, out_total_q, out_total_d;
	logic [1:0]             dir_q, dir_d;
	logic                   ok_q, ok_d, pend_q, pend_d, out_valid_q, out_valid_d;
	logic                   nb_ok, last_cell, grid_we, cnt_we;
	logic [CNT_W-1:0]       cnt_rd, cnt_wdata;

	always_comb begin
		if (num_rows_q == '0) begin
			rows_eff = RW'(1);
		end else if (32'(num_rows_q) > 32'(MAX_ROWS)) begin
			rows_eff = RW'(MAX_ROWS);
		end else begin
			rows_eff = RW'(num_rows_q);
		end
		if (num_cols_q == '0) begin
			cols_eff = CW'(1);
		end else if (32'(num_cols_q) > 32'(MAX_COLS)) begin
			cols_eff = CW'(MAX_COLS);
		end else begin
			cols_eff = CW'(num_cols_q);
		end
	end

	assign last_cell = (row_q == rows_eff - RW'(1)) && (col_q == cols_eff - CW'(1));

	always_comb begin
		unique case (dir_t'(dir_q))
			DIR_RIGHT: begin
				nb_ok   = (col_q + CW'(1)) < cols_eff;
				nb_addr = idx_q + IW'(1);
			end
			DIR_LEFT: begin
				nb_ok   = col_q != '0;
				nb_addr = idx_q - IW'(1);
			end
			DIR_UP: begin
				nb_ok   = row_q != '0;
				nb_addr = idx_q - IW'(cols_eff);
			end
			DIR_DOWN: begin
				nb_ok   = (row_q + RW'(1)) < rows_eff;
				nb_addr = idx_q + IW'(cols_eff);
			end
			default: begin
				nb_ok   = 1'b0;
				nb_addr = idx_q;
			end
		endcase
	end

	assign rd_addr    = (state_q == ST_NB_RD) ? nb_addr : idx_q;
	assign grid_wdata = VALUE_WIDTH'(cell_in.cell_value);
	assign cell_in.ready = (state_q == ST_LOAD);
	assign total_out.valid      = out_valid_q;
	assign total_out.path_total = out_total_q;

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		idx_d       = idx_q;
		val_d       = val_q;
		acc_d       = acc_q;
		total_d     = total_q;
		dir_d       = dir_q;
		ok_d        = ok_q;
		pend_d      = pend_q;
		out_valid_d = out_valid_q && !total_out.ready;
		out_total_d = out_total_q;
		grid_we     = 1'b0;
		cnt_we      = 1'b0;
		cnt_wdata   = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (cell_in.valid) begin
					grid_we = 1'b1;
					cnt_we  = 1'b1;
					if (last_cell) begin
						row_d   = '0;
						col_d   = '0;
						idx_d   = '0;
						pend_d  = 1'b0;
						total_d = '0;
						state_d = ST_CELL_RD;
					end else if (col_q + CW'(1) == cols_eff) begin
						col_d = '0;
						row_d = row_q + RW'(1);
						idx_d = idx_q + IW'(1);
					end else begin
						col_d = col_q + CW'(1);
						idx_d = idx_q + IW'(1);
					end
				end
			end
			ST_CELL_RD: begin
				state_d = ST_CELL_CHK;
			end
			ST_CELL_CHK: begin
				if (!cnt_rd[TOTAL_W]) begin
					val_d   = grid_rd;
					acc_d   = TOTAL_W'(1);
					ok_d    = 1'b1;
					dir_d   = DIR_RIGHT;
					state_d = ST_NB_RD;
				end
			end
			ST_NB_RD: begin
				if (nb_ok) begin
					state_d = ST_NB_CHK;
				end else if (dir_q == DIR_DOWN) begin
					state_d = ST_FINISH;
				end else begin
					dir_d = dir_q + 2'd1;
				end
			end
			ST_NB_CHK: begin
				if (grid_rd > val_q) begin
					if (!cnt_rd[TOTAL_W]) begin
						ok_d = 1'b0;
					end else begin
						acc_d = mod_add(acc_q, cnt_rd[TOTAL_W-1:0]);
					end
				end
				if (dir_q == DIR_DOWN) begin
					state_d = ST_FINISH;
				end else begin
					dir_d   = dir_q + 2'd1;
					state_d = ST_NB_RD;
				end
			end
			ST_FINISH: begin
				if (ok_q) begin
					cnt_we    = 1'b1;
					cnt_wdata = {1'b1, acc_q};
					total_d   = mod_add(total_q, acc_q);
				end else begin
					pend_d = 1'b1;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || total_out.ready) begin
					out_valid_d = 1'b1;
					out_total_d = total_q;
					row_d       = '0;
					col_d       = '0;
					idx_d       = '0;
					state_d     = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
		// advance the sweep past a settled cell or a finished visit
		if ((state_q == ST_FINISH) || (state_q == ST_CELL_CHK && cnt_rd[TOTAL_W])) begin
			if (last_cell) begin
				row_d = '0;
				col_d = '0;
				idx_d = '0;
				if (pend_d) begin
					pend_d  = 1'b0;
					state_d = ST_CELL_RD;
				end else begin
					state_d = ST_EMIT;
				end
			end else begin
				state_d = ST_CELL_RD;
				idx_d   = idx_q + IW'(1);
				if (col_q + CW'(1) == cols_eff) begin
					col_d = '0;
					row_d = row_q + RW'(1);
				end else begin
					col_d = col_q + CW'(1);
				end
			end
		end
		// drop the partial grid on a register write
		if (cfg_we) begin
			row_d = '0;
			col_d = '0;
			idx_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			num_rows_q  <= SIZE_RESET;
			num_cols_q  <= SIZE_RESET;
			row_q       <= '0;
			col_q       <= '0;
			idx_q       <= '0;
			dir_q       <= '0;
			ok_q        <= 1'b0;
			pend_q      <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_q       <= row_d;
			col_q       <= col_d;
			idx_q       <= idx_d;
			dir_q       <= dir_d;
			ok_q        <= ok_d;
			pend_q      <= pend_d;
			total_q     <= total_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NUM_ROWS: num_rows_q <= cfg_wdata;
					REG_NUM_COLS: num_cols_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q       <= val_d;
		acc_q       <= acc_d;
		out_total_q <= out_total_d;
	end

	gipc_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (SLOTS),
		.AW    (IW)
	) u_grid_ram (
		.clk   (clk),
		.we    (grid_we),
		.waddr (idx_q),
		.wdata (grid_wdata),
		.raddr (rd_addr),
		.rdata (grid_rd)
	);

	gipc_ram #(
		.WIDTH (CNT_W),
		.DEPTH (SLOTS),
		.AW    (IW)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (idx_q),
		.wdata (cnt_wdata),
		.raddr (rd_addr),
		.rdata (cnt_rd)
	);
endmodule
`default_nettype wire

// ===== rtl/gipc_checker.sv =====
// Port-level checker for the increasing-path counter, bound to the top level.
`default_nettype none
`include "grid_increasing_path_counter_assert.svh"
module gipc_checker import gipc_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [TOTAL_W-1:0] path_total
);
	`GIPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`GIPC_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(path_total), "result changed while stalled")
	`GIPC_ASSERT(a_total_range, out_valid |-> path_total < PATH_PRIME, "total not reduced")
	`GIPC_ASSERT(a_rise_after_sweep, $rose(out_valid) |-> $past(!in_ready), "result without a sweep")
	`GIPC_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result during reset")
endmodule

bind grid_increasing_path_counter gipc_checker u_gipc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (cell_in.ready),
	.out_valid  (total_out.valid),
	.out_ready  (total_out.ready),
	.path_total (total_out.path_total)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the grid increasing-path counter.
`timescale 1ns / 100ps
`default_nettype none
module tb_top import gipc_pkg::*; ;

	localparam int  SLOTS       = DEF_MAX_ROWS * DEF_MAX_COLS;
	localparam int  CYCLE_LIMIT = 5000000;
	localparam int  DRAIN_WAIT  = 40;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	gipc_cell_if  cell_if();
	gipc_total_if total_if();

	grid_increasing_path_counter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cell_in   (cell_if.sink),
		.total_out (total_if.source)
	);

	logic [CELL_W-1:0]  cell_vals [SLOTS];
	logic [TOTAL_W-1:0] cell_paths [SLOTS];
	int                 visit_seq [SLOTS];
	logic [TOTAL_W-1:0] totals_due [$];
	logic [CFG_W-1:0]   rows_reg;
	logic [CFG_W-1:0]   cols_reg;
	int  load_pos;
	int  errors;
	int  cells_sent;
	int  totals_seen;
	int  cycle_count;
	int  hold_req;
	bit  idle_in;
	bit  idle_out;

	function automatic int eff_size(input logic [CFG_W-1:0] v, input int top);
		if (v == 0) return 1;
		if (v > top) return top;
		return v;
	endfunction

	function automatic logic [TOTAL_W-1:0] count_paths(input int rows, input int cols);
		int n, k, pos, key, r, c, d, nr, nc, nb;
		longint acc, sum;
		n = rows * cols;
		for (k = 0; k < n; k++) visit_seq[k] = k;
		for (k = 1; k < n; k++) begin
			key = visit_seq[k];
			pos = k;
			while (pos > 0 && cell_vals[visit_seq[pos-1]] < cell_vals[key]) begin
				visit_seq[pos] = visit_seq[pos-1];
				pos--;
			end
			visit_seq[pos] = key;
		end
		sum = 0;
		for (k = 0; k < n; k++) begin
			r = visit_seq[k] / cols;
			c = visit_seq[k] % cols;
			acc = 1;
			for (d = 0; d < 4; d++) begin
				nr = r + ((d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0);
				nc = c + ((d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0);
				if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
				nb = nr * cols + nc;
				if (cell_vals[nb] > cell_vals[visit_seq[k]])
					acc = (acc + cell_paths[nb]) % longint'(PATH_PRIME);
			end
			cell_paths[visit_seq[k]] = TOTAL_W'(acc);
			sum = (sum + acc) % longint'(PATH_PRIME);
		end
		return TOTAL_W'(sum);
	endfunction

	task automatic report(input string what, input logic [TOTAL_W-1:0] got,
		input logic [TOTAL_W-1:0] want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		errors++;
	endtask

	task automatic load_cell(input logic [CELL_W-1:0] v);
		logic rdy;
		int n;
		if (idle_in && $urandom_range(0, 99) < 32) begin
			cell_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cell_if.valid      <= 1'b1;
		cell_if.cell_value <= v;
		do begin
			@(negedge clk);
			rdy = cell_if.ready;
			@(posedge clk);
		end while (!rdy);
		cells_sent++;
		n = eff_size(rows_reg, DEF_MAX_ROWS) * eff_size(cols_reg, DEF_MAX_COLS);
		if (load_pos >= n) load_pos = 0;
		cell_vals[load_pos] = v;
		load_pos++;
		if (load_pos >= n) begin
			totals_due.push_back(count_paths(eff_size(rows_reg, DEF_MAX_ROWS),
				eff_size(cols_reg, DEF_MAX_COLS)));
			load_pos = 0;
		end
	endtask

	task automatic wait_drained();
		cell_if.valid <= 1'b0;
		while (totals_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NUM_ROWS) rows_reg = v;
		else cols_reg = v;
		load_pos = 0;
	endtask

	task automatic set_size(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
		write_reg(REG_NUM_ROWS, r);
		write_reg(REG_NUM_COLS, c);
	endtask

	// mode 0 random, 1 narrow range, 2 rising snake, 3 falling snake, 4 zero, 5 max
	task automatic load_grid(input int mode, input int count);
		int n, k, r, c, snake;
		n = eff_size(rows_reg, DEF_MAX_ROWS) * eff_size(cols_reg, DEF_MAX_COLS);
		c = eff_size(cols_reg, DEF_MAX_COLS);
		if (count < 0) count = n;
		for (k = 0; k < count; k++) begin
			r = k / c;
			snake = (r % 2 == 0) ? k : r * c + (c - 1 - k % c);
			case (mode)
				0: load_cell(CELL_W'($urandom()));
				1: load_cell(CELL_W'($urandom_range(0, 3)));
				2: load_cell(CELL_W'(snake));
				3: load_cell(CELL_W'(32'hFFFFF - snake));
				4: load_cell('0);
				default: load_cell('1);
			endcase
		end
	endtask

	task automatic test_single_cell();
		set_size(6'd1, 6'd1);
		load_grid(4, -1);
		load_grid(5, -1);
		load_grid(0, -1);
	endtask

	task automatic test_size_clamp();
		set_size(6'd0, 6'd63);
		load_grid(2, -1);
		set_size(6'd63, 6'd0);
		load_grid(0, -1);
	endtask

	task automatic test_flat_grids();
		set_size(6'd3, 6'd3);
		load_grid(4, -1);
		load_grid(5, -1);
		load_grid(1, -1);
	endtask

	task automatic test_snake_paths();
		set_size(6'd4, 6'd5);
		load_grid(2, -1);
		load_grid(3, -1);
	endtask

	task automatic test_partial_drop();
		set_size(6'd3, 6'd3);
		load_grid(0, 4);
		write_reg(REG_NUM_COLS, 6'd4);
		load_grid(0, -1);
	endtask

	task automatic test_max_extent();
		set_size(6'd32, 6'd4);
		load_grid(0, -1);
		set_size(6'd4, 6'd32);
		load_grid(0, -1);
	endtask

	task automatic test_backpressure();
		set_size(6'd2, 6'd2);
		hold_req = 3000;
		repeat (12) load_grid(0, -1);
		wait_drained();
	endtask

	task automatic test_random_grids();
		int start, mode;
		start = cells_sent;
		while (cells_sent - start < 200) begin
			idle_in  = (cells_sent - start < 40 || cells_sent - start > 140);
			idle_out = idle_in;
			set_size(CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(1, 6)));
			if ($urandom_range(0, 9) == 0) begin
				load_grid(0, $urandom_range(1, 3));
				write_reg(REG_NUM_ROWS, CFG_W'($urandom_range(1, 5)));
			end
			repeat ($urandom_range(1, 6)) begin
				mode = $urandom_range(0, 9);
				load_grid(mode < 5 ? 0 : mode < 8 ? 1 : mode - 6, -1);
			end
		end
		idle_in  = 1;
		idle_out = 1;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int hold_left;
		logic v, r;
		logic [TOTAL_W-1:0] d;
		hold_left = 0;
		total_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			v = total_if.valid;
			r = total_if.ready;
			d = total_if.path_total;
			@(posedge clk);
			if (v && r) begin
				totals_seen++;
				if (totals_due.size() == 0) report("unexpected total", d, '0);
				else if (d != totals_due[0]) report("path_total", d, totals_due.pop_front());
				else void'(totals_due.pop_front());
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				total_if.ready <= 1'b0;
			end else begin
				total_if.ready <= !(idle_out && $urandom_range(0, 99) < 32);
			end
		end
	end

	initial begin
		errors      = 0;
		cells_sent  = 0;
		totals_seen = 0;
		hold_req    = 0;
		load_pos    = 0;
		idle_in     = 1;
		idle_out    = 1;
		rows_reg    = SIZE_RESET;
		cols_reg    = SIZE_RESET;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_NUM_ROWS;
		cfg_wdata   = '0;
		cell_if.valid      = 1'b0;
		cell_if.cell_value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_cell();
		test_size_clamp();
		test_flat_grids();
		test_snake_paths();
		test_partial_drop();
		test_max_extent();
		test_backpressure();
		test_random_grids();
		wait_drained();
		while (totals_due.size() != 0) begin
			report("missing total", '0, totals_due.pop_front());
		end
		$display("Loaded %0d cells and checked %0d path totals on grids up to 32 rows or columns,",
			cells_sent, totals_seen);
		$display("with size clamping, partial-grid drops, output stalls and random gaps.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/gipc_pkg.sv
rtl/gipc_ifs.sv
rtl/gipc_ram.sv
rtl/grid_increasing_path_counter.sv
rtl/gipc_checker.sv
dv/tb_top.sv
